[rtl/positional_list_engine_top_assert.svh]
// Assertion macros for the positional list engine.
// Used by positional_list_engine_top; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLE_ASSERT_IMP(label, ante, cons)
`define PLE_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_ctrl, ple_dpath and positional_list_engine_top.
package ple_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [2:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_UPDATE    = 3'd6,
        CMD_READ_ALL  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] item;
        logic               last;
    } t_rsp;

    typedef enum logic [1:0] {
        DP_HOLD,
        DP_EDIT,
        DP_READ_START,
        DP_READ_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_ctl;

    typedef struct packed {
        logic count_zero;
        logic read_last;
    } t_dp_stat;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

[rtl/ple_ctrl.sv]
// Controller for the positional list engine: request and response handshake.
// Depends on ple_pkg; drives ple_dpath through t_dp_ctl.
module ple_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  ple_pkg::t_cmd     i_req_cmd,
    input  logic              i_rsp_stall,
    input  ple_pkg::t_dp_stat i_stat,
    output logic              o_req_stall,
    output logic              o_rsp_valid,
    output ple_pkg::t_dp_ctl  o_ctl
);

    ple_pkg::t_state r_state, n_state;
    logic            r_rsp_valid, n_rsp_valid;
    logic            out_free;

    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp_valid = r_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ple_pkg::S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        o_ctl.op    = ple_pkg::DP_HOLD;
        o_req_stall = 1'b1;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                o_req_stall = !out_free;
                if (i_req_valid && out_free) begin
                    if (i_req_cmd == ple_pkg::CMD_READ_ALL && !i_stat.count_zero) begin
                        o_ctl.op = ple_pkg::DP_READ_START;
                        n_state  = ple_pkg::S_READ;
                    end else begin
                        o_ctl.op    = ple_pkg::DP_EDIT;
                        n_rsp_valid = 1'b1;
                    end
                end
            end
            ple_pkg::S_READ: begin
                if (out_free) begin
                    o_ctl.op    = ple_pkg::DP_READ_STEP;
                    n_rsp_valid = 1'b1;
                    if (i_stat.read_last) begin
                        n_state = ple_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/ple_dpath.sv]
// Datapath for the positional list engine: entry registers, count, response register.
// Depends on ple_pkg; sequenced by ple_ctrl through t_dp_ctl.
module ple_dpath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ple_pkg::t_req     i_req,
    input  ple_pkg::t_dp_ctl  i_ctl,
    output ple_pkg::t_dp_stat o_stat,
    output ple_pkg::t_rsp     o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_entry [CAPACITY];
    logic signed [31:0] n_entry [CAPACITY];
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    ple_pkg::t_rsp      r_rsp, n_rsp;

    logic [7:0]         pos8, cnt8, idx8;
    logic               pos_ok, pos_ok_ins, full, empty;
    logic               do_ins, do_del, do_upd, do_rot;
    ple_pkg::t_status   status;

    assign pos8  = {1'b0, i_req.position};
    assign cnt8  = 8'(r_count);
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    assign pos_ok     = (pos8 != 8'd0) && (pos8 <= cnt8);
    assign pos_ok_ins = (pos8 != 8'd0) && (pos8 <= cnt8 + 8'd1);

    assign o_stat.count_zero = empty;
    assign o_stat.read_last  = (r_left == CW'(1));
    assign o_rsp             = r_rsp;

    always_comb begin
        status = ple_pkg::ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        do_upd = 1'b0;
        idx8   = 8'd0;
        unique case (i_req.cmd)
            ple_pkg::CMD_INS_FIRST: begin
                if (full) status = ple_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ple_pkg::CMD_INS_LAST: begin
                idx8 = cnt8;
                if (full) status = ple_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ple_pkg::CMD_INS_POS: begin
                idx8 = pos8 - 8'd1;
                if (!pos_ok_ins) status = ple_pkg::ST_RANGE;
                else if (full) status = ple_pkg::ST_FULL;
                else do_ins = 1'b1;
            end
            ple_pkg::CMD_DEL_FIRST: begin
                if (empty) status = ple_pkg::ST_EMPTY;
                else do_del = 1'b1;
            end
            ple_pkg::CMD_DEL_LAST: begin
                idx8 = cnt8 - 8'd1;
                if (empty) status = ple_pkg::ST_EMPTY;
                else do_del = 1'b1;
            end
            ple_pkg::CMD_DEL_POS: begin
                idx8 = pos8 - 8'd1;
                if (empty) status = ple_pkg::ST_EMPTY;
                else if (!pos_ok) status = ple_pkg::ST_RANGE;
                else do_del = 1'b1;
            end
            ple_pkg::CMD_UPDATE: begin
                idx8 = pos8 - 8'd1;
                if (!pos_ok) status = ple_pkg::ST_RANGE;
                else do_upd = 1'b1;
            end
            ple_pkg::CMD_READ_ALL: begin
                status = ple_pkg::ST_EMPTY;
            end
            default: begin
                status = ple_pkg::ST_OK;
            end
        endcase
    end

    assign do_rot = (i_ctl.op == ple_pkg::DP_READ_STEP);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
        logic edit;
        assign edit = (i_ctl.op == ple_pkg::DP_EDIT);

        always_comb begin
            n_entry[g] = r_entry[g];
            if (edit && do_ins) begin
                if (8'(g) == idx8) n_entry[g] = i_req.value;
                else if (8'(g) > idx8) n_entry[g] = r_entry[PREV];
            end else if (edit && do_del) begin
                if (8'(g) >= idx8) n_entry[g] = r_entry[NEXT];
            end else if (edit && do_upd) begin
                if (8'(g) == idx8) n_entry[g] = i_req.value;
            end else if (do_rot) begin
                if (8'(g) < cnt8 - 8'd1) n_entry[g] = r_entry[NEXT];
                else if (8'(g) == cnt8 - 8'd1) n_entry[g] = r_entry[0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_entry[g] <= n_entry[g];
        end
    end

    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        n_rsp   = r_rsp;
        unique case (i_ctl.op)
            ple_pkg::DP_HOLD: begin
                n_count = r_count;
            end
            ple_pkg::DP_EDIT: begin
                if (do_ins) n_count = r_count + CW'(1);
                else if (do_del) n_count = r_count - CW'(1);
                n_rsp.status = status;
                n_rsp.item   = '0;
                n_rsp.last   = 1'b1;
            end
            ple_pkg::DP_READ_START: begin
                n_left = r_count;
            end
            ple_pkg::DP_READ_STEP: begin
                n_left       = r_left - CW'(1);
                n_rsp.status = ple_pkg::ST_OK;
                n_rsp.item   = r_entry[0];
                n_rsp.last   = o_stat.read_last;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
        end
        r_rsp <= n_rsp;
    end

endmodule

[rtl/positional_list_engine_top.sv]
// Top level of the positional list engine.
// Depends on ple_pkg, ple_ctrl, ple_dpath and positional_list_engine_top_assert.svh.
//
// Usage:
//   Request channel i_req_valid / o_req_stall / i_req carries a command, a 1-based
//   position and a signed word. Response channel o_rsp_valid / i_rsp_stall / o_rsp
//   carries status, item and last.
//   Edits (insert, delete, update) take one cycle and give one response with last
//   set, valid the cycle after the request is taken. A new request may be taken
//   every cycle while the response side keeps up.
//   Read-all gives count responses, one per cycle, the first two cycles after the
//   request; the entry registers rotate by one position per response, so the
//   block takes no request during read-out. An empty list gives one response
//   with status empty.
//   A stalled response holds; the block takes no new request while it would
//   overwrite it.
//   Reset empties the list and drops any pending response; entries need no clearing.
`include "positional_list_engine_top_assert.svh"
module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ple_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ple_pkg::t_rsp o_rsp
);

    ple_pkg::t_dp_ctl  ctl;
    ple_pkg::t_dp_stat stat;

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_cmd   (i_req.cmd),
        .i_rsp_stall (i_rsp_stall),
        .i_stat      (stat),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_ctl       (ctl)
    );

    ple_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

    `PLE_ASSERT_IMP(a_hold_when_blocked, o_rsp_valid && i_rsp_stall, o_req_stall)
    `PLE_ASSERT_NXT(a_edit_responds, i_req_valid && !o_req_stall && i_req.cmd != ple_pkg::CMD_READ_ALL, o_rsp_valid && o_rsp.last)
    `PLE_ASSERT_IMP(a_error_is_final, o_rsp_valid && o_rsp.status != ple_pkg::ST_OK, o_rsp.last && o_rsp.item == 32'sd0)

endmodule
